/* hw/rtl/sofm_pkg.sv */
// Shared types and constants for the set overlap first-match block.
package sofm_pkg;

	localparam int MAX_SETS_DEF     = 64;
	localparam int MAX_SET_SIZE_DEF = 8;
	localparam int NODE_BITS_DEF    = 16;

	localparam int NODE_ID_W = 16;
	localparam int MIN_W     = 4;
	localparam int IDX_OUT_W = 6;
	localparam int OV_OUT_W  = 4;

	localparam logic [MIN_W-1:0]    MIN_COMMON_RST = 4'd1;
	localparam logic [OV_OUT_W-1:0] OV_SAT         = 4'hF;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic {
		ST_RUN,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic                 status;
		logic                 match_ready;
		logic                 found;
		logic [IDX_OUT_W-1:0] set_index;
		logic [OV_OUT_W-1:0]  overlap;
	} res_t;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic clr;
		logic load_wr;
		logic load_close;
		logic qry_elem;
		logic qry_end;
		logic shift;
	} cell_ctl_t;

endpackage

/* hw/rtl/sofm_cell.sv */
// One stored-set cell: elements, size, overlap counter and a stage of the result scan chain.
module sofm_cell #(
	parameter int CELL_IDX = 0,
	parameter int SET_SIZE = sofm_pkg::MAX_SET_SIZE_DEF,
	parameter int KEY_W    = sofm_pkg::NODE_BITS_DEF,
	parameter int SC_W     = 7,
	localparam int SZ_W    = $clog2(SET_SIZE + 1),
	localparam int SLOT_W  = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sofm_pkg::cell_ctl_t           ctl,
	input  logic [SC_W-1:0]               set_count,
	input  logic [SLOT_W-1:0]             load_slot,
	input  logic [KEY_W-1:0]              key,
	input  logic [SZ_W-1:0]               close_size,
	input  logic [sofm_pkg::MIN_W-1:0]    min_common,
	input  logic                          hit_in,
	input  logic [SZ_W-1:0]               ov_in,
	output logic                          hit_out,
	output logic [SZ_W-1:0]               ov_out
);

	localparam int CMP_W  = (SZ_W > sofm_pkg::MIN_W) ? SZ_W : sofm_pkg::MIN_W;

	logic [KEY_W-1:0] elem_q [SET_SIZE];
	logic [SZ_W-1:0]  size_q;
	logic [SZ_W-1:0]  cnt_q;
	logic [SZ_W-1:0]  cnt_nxt;
	logic             hit_q;
	logic [SZ_W-1:0]  ov_q;
	logic             sel;
	logic             active;
	logic             match;
	logic             inc;

	assign sel    = (set_count == SC_W'(CELL_IDX));
	assign active = (SC_W'(CELL_IDX) < set_count);

	always_comb begin
		match = 1'b0;
		for (int j = 0; j < SET_SIZE; j++) begin
			if ((SZ_W'(j) < size_q) && (elem_q[j] == key)) begin
				match = 1'b1;
			end
		end
	end

	assign inc     = ctl.qry_elem && active && match;
	assign cnt_nxt = cnt_q + SZ_W'(inc);

	always_ff @(posedge clk) begin
		if (ctl.load_wr && sel) begin
			elem_q[load_slot] <= key;
		end
		if (ctl.load_close && sel) begin
			size_q <= close_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clr || ctl.qry_end || (ctl.load_close && sel)) begin
			cnt_q <= '0;
		end else if (inc) begin
			cnt_q <= cnt_nxt;
		end
	end

	// snapshot at query end, then shift toward cell 0 one stage per cycle while shift is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			ov_q  <= '0;
		end else if (ctl.qry_end) begin
			hit_q <= active && (CMP_W'(cnt_nxt) >= CMP_W'(min_common));
			ov_q  <= cnt_nxt;
		end else if (ctl.shift) begin
			hit_q <= hit_in;
			ov_q  <= ov_in;
		end
	end

	assign hit_out = hit_q;
	assign ov_out  = ov_q;

endmodule

/* hw/rtl/sofm_obuf.sv */
// Output register with a skid stage for result items.
module sofm_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sofm_pkg::res_t  din,
	input  logic            res_stall,
	output logic            res_valid,
	output sofm_pkg::res_t  dout,
	output logic            skid_full
);

	logic           out_v_q;
	sofm_pkg::res_t out_q;
	logic           skid_v_q;
	sofm_pkg::res_t skid_q;
	logic           free;

	assign free = !out_v_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= push;
			end else begin
				out_v_q  <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= din;
				end
			end else if (push) begin
				out_q <= din;
			end
		end else if (push) begin
			skid_q <= din;
		end
	end

	assign res_valid = out_v_q;
	assign dout      = out_q;
	assign skid_full = skid_v_q;

endmodule

/* hw/rtl/set_overlap_first_match.sv */
// Set overlap first-match top level: sequencer, cell row and output buffer.
//
// Requests enter on req_valid/req_stall with action, node_id, has_element and
// end_of_set; each request gives exactly one result on res_valid/res_stall.
// A load request writes node_id into the set being filled; end_of_set closes
// it. Query requests broadcast node_id to every stored-set cell, and each cell
// counts hits. min_common is written through cfg_we/cfg_data.
// Every request except a query request that ends a set pushes its result into
// the output buffer when it is taken. That one triggers a scan: hit flags are
// snapshotted into a shift chain and move toward cell 0 one cell per cycle; the
// scan stops at the first hit or at the last stored set and then pushes its
// result, and req_stall is high while it runs. Otherwise one request per cycle.
// Results go through an output register plus a skid stage, so a request is
// still taken while one result waits; req_stall rises once the skid is full.
// Reset empties the table, clears counters and sets min_common to 1. Stored
// elements are not cleared; only written entries are ever compared.
module set_overlap_first_match #(
	parameter int MAX_SETS     = sofm_pkg::MAX_SETS_DEF,
	parameter int MAX_SET_SIZE = sofm_pkg::MAX_SET_SIZE_DEF,
	parameter int NODE_BITS    = sofm_pkg::NODE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sofm_pkg::MIN_W-1:0]        cfg_data,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [1:0]                        action,
	input  logic [sofm_pkg::NODE_ID_W-1:0]    node_id,
	input  logic                              has_element,
	input  logic                              end_of_set,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              status,
	output logic                              match_ready,
	output logic                              found,
	output logic [sofm_pkg::IDX_OUT_W-1:0]    set_index,
	output logic [sofm_pkg::OV_OUT_W-1:0]     overlap
);

	localparam int KEY_W  = (NODE_BITS < sofm_pkg::NODE_ID_W) ? NODE_BITS : sofm_pkg::NODE_ID_W;
	localparam int SZ_W   = $clog2(MAX_SET_SIZE + 1);
	localparam int SLOT_W = (MAX_SET_SIZE > 1) ? $clog2(MAX_SET_SIZE) : 1;
	localparam int SC_W   = $clog2(MAX_SETS + 1);
	localparam int IDX_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int CMP_W  = (SZ_W > sofm_pkg::OV_OUT_W) ? SZ_W : sofm_pkg::OV_OUT_W;

	sofm_pkg::state_t     state_q, state_d;
	sofm_pkg::action_t    act;
	sofm_pkg::cell_ctl_t  ctl;
	sofm_pkg::res_t       imm_res, scan_res, push_res, out_res;

	logic [sofm_pkg::MIN_W-1:0] min_common_q;
	logic [SC_W-1:0]            set_count_q;
	logic [SZ_W-1:0]            fill_q;
	logic [SZ_W-1:0]            qlen_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       st_q;

	logic                       accept;
	logic                       skid_full;
	logic                       full;
	logic                       is_load, is_query, is_clear;
	logic                       load_wr, load_close, qry_elem, qry_end;
	logic                       status_now;
	logic [SZ_W-1:0]            close_size;
	logic [KEY_W-1:0]           key;
	logic                       scan_push, shift, last;
	logic [CMP_W-1:0]           head_ov_ext;

	logic                       hit_chain [MAX_SETS+1];
	logic [SZ_W-1:0]            ov_chain  [MAX_SETS+1];

	assign act       = sofm_pkg::action_t'(action);
	assign req_stall = (state_q != sofm_pkg::ST_RUN) || skid_full;
	assign accept    = req_valid && !req_stall;
	assign key       = node_id[KEY_W-1:0];
	assign full      = (set_count_q >= SC_W'(MAX_SETS));

	always_comb begin
		is_clear = 1'b0;
		is_load  = 1'b0;
		is_query = 1'b0;
		case (act)
			sofm_pkg::ACT_CLEAR: is_clear = 1'b1;
			sofm_pkg::ACT_LOAD:  is_load  = 1'b1;
			sofm_pkg::ACT_QUERY: is_query = 1'b1;
			sofm_pkg::ACT_NOP:   ;
			default:             ;
		endcase
	end

	assign load_wr    = accept && is_load && has_element && !full &&
	                    (fill_q < SZ_W'(MAX_SET_SIZE));
	assign load_close = accept && is_load && end_of_set && !full;
	assign close_size = fill_q + SZ_W'(load_wr);
	assign qry_elem   = accept && is_query && has_element && (qlen_q < SZ_W'(MAX_SET_SIZE));
	assign qry_end    = accept && is_query && end_of_set;

	always_comb begin
		status_now = 1'b0;
		if (is_load) begin
			status_now = (has_element && (full || (fill_q >= SZ_W'(MAX_SET_SIZE)))) ||
			             (end_of_set && full);
		end else if (is_query) begin
			status_now = has_element && (qlen_q >= SZ_W'(MAX_SET_SIZE));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_common_q <= sofm_pkg::MIN_COMMON_RST;
		end else if (cfg_we) begin
			min_common_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count_q <= '0;
			fill_q      <= '0;
			qlen_q      <= '0;
		end else if (accept) begin
			if (is_clear) begin
				set_count_q <= '0;
				fill_q      <= '0;
				qlen_q      <= '0;
			end else if (is_load) begin
				if (end_of_set) begin
					fill_q <= '0;
				end else if (load_wr) begin
					fill_q <= fill_q + SZ_W'(1);
				end
				if (load_close) begin
					set_count_q <= set_count_q + SC_W'(1);
				end
			end else if (is_query) begin
				if (end_of_set) begin
					qlen_q <= '0;
				end else if (qry_elem) begin
					qlen_q <= qlen_q + SZ_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sofm_pkg::ST_RUN;
			idx_q   <= '0;
			st_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (qry_end) begin
				idx_q <= '0;
				st_q  <= status_now;
			end else if (shift) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// the scan ends at the first hit or at the last closed set
	assign last = (SC_W'(idx_q) + SC_W'(1)) >= set_count_q;

	always_comb begin
		state_d   = state_q;
		scan_push = 1'b0;
		shift     = 1'b0;
		case (state_q)
			sofm_pkg::ST_RUN: begin
				if (qry_end) begin
					state_d = sofm_pkg::ST_SCAN;
				end
			end
			sofm_pkg::ST_SCAN: begin
				if (hit_chain[0] || last) begin
					scan_push = 1'b1;
					state_d   = sofm_pkg::ST_RUN;
				end else begin
					shift = 1'b1;
				end
			end
			default: state_d = sofm_pkg::ST_RUN;
		endcase
	end

	assign head_ov_ext = CMP_W'(ov_chain[0]);

	always_comb begin
		imm_res        = '0;
		imm_res.status = status_now;

		scan_res             = '0;
		scan_res.status      = st_q;
		scan_res.match_ready = 1'b1;
		if (hit_chain[0]) begin
			scan_res.found     = 1'b1;
			scan_res.set_index = sofm_pkg::IDX_OUT_W'(idx_q);
			scan_res.overlap   = (head_ov_ext > CMP_W'(sofm_pkg::OV_SAT)) ?
			                     sofm_pkg::OV_SAT : sofm_pkg::OV_OUT_W'(head_ov_ext);
		end

		push_res = scan_push ? scan_res : imm_res;
	end

	always_comb begin
		ctl            = '0;
		ctl.clr        = accept && is_clear;
		ctl.load_wr    = load_wr;
		ctl.load_close = load_close;
		ctl.qry_elem   = qry_elem;
		ctl.qry_end    = qry_end;
		ctl.shift      = shift;
	end

	assign hit_chain[MAX_SETS] = 1'b0;
	assign ov_chain[MAX_SETS]  = '0;

	for (genvar i = 0; i < MAX_SETS; i++) begin : g_cell
		sofm_cell #(
			.CELL_IDX (i),
			.SET_SIZE (MAX_SET_SIZE),
			.KEY_W    (KEY_W),
			.SC_W     (SC_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.set_count  (set_count_q),
			.load_slot  (fill_q[SLOT_W-1:0]),
			.key        (key),
			.close_size (close_size),
			.min_common (min_common_q),
			.hit_in     (hit_chain[i+1]),
			.ov_in      (ov_chain[i+1]),
			.hit_out    (hit_chain[i]),
			.ov_out     (ov_chain[i])
		);
	end

	sofm_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      ((accept && !qry_end) || scan_push),
		.din       (push_res),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.dout      (out_res),
		.skid_full (skid_full)
	);

	assign status      = out_res.status;
	assign match_ready = out_res.match_ready;
	assign found       = out_res.found;
	assign set_index   = out_res.set_index;
	assign overlap     = out_res.overlap;

endmodule

/* hw/rtl/sofm_chk.sv */
// Port-level checker for the set overlap first-match block, bound to the top level.
module sofm_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_stall,
	input logic                            status,
	input logic                            match_ready,
	input logic                            found,
	input logic [sofm_pkg::IDX_OUT_W-1:0]  set_index,
	input logic [sofm_pkg::OV_OUT_W-1:0]   overlap
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid &&
		$stable({status, match_ready, found, set_index, overlap}))
		else $error("result changed while stalled");

	// match fields only carry data on a query-end result
	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !match_ready |-> !found && set_index == '0 && overlap == '0)
		else $error("match fields set on a non query-end result");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && match_ready && !found |-> set_index == '0 && overlap == '0)
		else $error("index or overlap set without a match");

endmodule

bind set_overlap_first_match sofm_chk u_sofm_chk (.*);
